@@ rtl/tes_pkg.sv @@
// Shared constants, types and state encoding for the trace event statistics core.
`default_nettype none
package tes_pkg;

   localparam int ID_BITS_DEF    = 16;
   localparam int COUNT_BITS_DEF = 32;
   localparam int WIDE_BITS      = 64;

   localparam int NUM_KINDS  = 7;
   localparam int NUM_SCOPES = 3;
   localparam int NUM_MAPS   = 4;
   localparam int NUM_STATS  = 14;

   localparam int KIND_BITS     = 3;
   localparam int SCOPE_BITS    = 3;
   localparam int ID_FIELD_BITS = 16;
   localparam int INDEX_BITS    = 4;
   localparam int STAT_BITS     = 32;
   localparam int DIST_BITS     = 17;

   localparam int ROW_BITS     = 64;
   localparam int ROW_OFF_BITS = 6;

   localparam int REQ_DATA_BITS = 72;
   localparam int RSP_DATA_BITS = 40;

   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   localparam logic [KIND_BITS-1:0] KIND_MON_STATE = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_INVALID   = 3'd7;

   localparam int SCOPE_UNKNOWN = 0;
   localparam int SCOPE_SIM     = 1;
   localparam int SCOPE_NODE    = 2;

   localparam int MAP_NODES = 0;

   localparam logic [INDEX_BITS-1:0] STAT_FIRST_SCOPE = 4'd7;
   localparam logic [INDEX_BITS-1:0] STAT_FIRST_DIST  = 4'd10;
   localparam logic [INDEX_BITS-1:0] STAT_LAST        = 4'd13;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_REPORT
   } tes_state_type;

   typedef struct packed {
      logic clear_step;
      logic capture;
      logic update;
      logic rep_start;
      logic rep_load;
   } tes_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic rep_last;
      logic rsp_valid;
   } tes_status_type;

endpackage
`default_nettype wire

@@ rtl/tes_bitmap.sv @@
// One seen-id bitmap: row memory with read-modify-write marking and a distinct counter.
`default_nettype none
module tes_bitmap #(
   parameter int ID_BITS = tes_pkg::ID_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 clear_en,
   input  wire logic [ID_BITS-tes_pkg::ROW_OFF_BITS-1:0] clear_addr,
   input  wire logic                                 rd_en,
   input  wire logic [ID_BITS-1:0]                   rd_id,
   input  wire logic                                 upd_en,
   output      logic [tes_pkg::DIST_BITS-1:0]        distinct
);
   import tes_pkg::*;

   localparam int ADDR_BITS = ID_BITS - ROW_OFF_BITS;
   localparam int ROWS      = 1 << ADDR_BITS;

   logic [ROW_BITS-1:0]     mem [ROWS];
   logic [ROW_BITS-1:0]     row_ff;
   logic [ADDR_BITS-1:0]    addr_ff;
   logic [ROW_OFF_BITS-1:0] off_ff;
   logic [DIST_BITS-1:0]    dist_ff;
   logic [DIST_BITS-1:0]    dist_in;
   logic [ROW_BITS-1:0]     mask;
   logic                    hit;
   logic                    set_new;

   assign mask    = ROW_BITS'(1) << off_ff;
   assign hit     = row_ff[off_ff];
   assign set_new = upd_en && !hit;

   always_ff @(posedge clock) begin
      if (clear_en) begin
         mem[clear_addr] <= '0;
      end else if (set_new) begin
         mem[addr_ff] <= row_ff | mask;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         row_ff  <= mem[rd_id[ID_BITS-1:ROW_OFF_BITS]];
         addr_ff <= rd_id[ID_BITS-1:ROW_OFF_BITS];
         off_ff  <= rd_id[ROW_OFF_BITS-1:0];
      end
   end

   always_comb begin
      dist_in = dist_ff;
      if (set_new && !(&dist_ff)) begin
         dist_in = dist_ff + DIST_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff <= '0;
      end else begin
         dist_ff <= dist_in;
      end
   end

   assign distinct = dist_ff;

endmodule
`default_nettype wire

@@ rtl/tes_datapath.sv @@
// Datapath: saturating counters, four bitmaps, clear sweep and report output register.
`default_nettype none
module tes_datapath #(
   parameter int ID_BITS    = tes_pkg::ID_BITS_DEF,
   parameter int COUNT_BITS = tes_pkg::COUNT_BITS_DEF
) (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire tes_pkg::tes_cmd_type                         cmd,
   output      tes_pkg::tes_status_type                      status,
   input  wire logic [tes_pkg::KIND_BITS-1:0]                req_kind,
   input  wire logic [tes_pkg::SCOPE_BITS-1:0]               req_scope,
   input  wire logic [tes_pkg::NUM_MAPS-1:0][tes_pkg::ID_FIELD_BITS-1:0] req_ids,
   input  wire logic                                         rsp_ready,
   output      logic [tes_pkg::INDEX_BITS-1:0]               rsp_index,
   output      logic [tes_pkg::STAT_BITS-1:0]                rsp_value,
   output      logic                                         rsp_last
);
   import tes_pkg::*;

   localparam int ADDR_BITS = ID_BITS - ROW_OFF_BITS;

   logic [COUNT_BITS-1:0] event_counts_ff [NUM_KINDS];
   logic [COUNT_BITS-1:0] scope_counts_ff [NUM_SCOPES];
   logic [KIND_BITS-1:0]  kind_ff;
   logic [SCOPE_BITS-1:0] scope_ff;
   logic [ADDR_BITS-1:0]  clear_addr_ff;
   logic [INDEX_BITS-1:0] idx_ff;
   logic                  rsp_valid_ff;
   logic [INDEX_BITS-1:0] rsp_index_ff;
   logic [STAT_BITS-1:0]  rsp_value_ff;
   logic                  rsp_last_ff;

   logic [NUM_MAPS-1:0]                 map_en;
   logic [NUM_MAPS-1:0][DIST_BITS-1:0]  distinct;
   logic [INDEX_BITS-1:0]               scope_sel;
   logic [INDEX_BITS-1:0]               dist_sel;
   logic [WIDE_BITS-1:0]                wide_val;
   logic [STAT_BITS-1:0]                stat_in;

   // node map follows the node scope flag; the monitor maps follow mon-state events
   always_comb begin
      for (int m = 0; m < NUM_MAPS; m++) begin
         map_en[m] = (kind_ff == KIND_MON_STATE);
      end
      map_en[MAP_NODES] = scope_ff[SCOPE_NODE];
   end

   for (genvar g = 0; g < NUM_MAPS; g++) begin : g_map
      tes_bitmap #(
         .ID_BITS (ID_BITS)
      ) u_bitmap (
         .clock      (clock),
         .reset      (reset),
         .clear_en   (cmd.clear_step),
         .clear_addr (clear_addr_ff),
         .rd_en      (cmd.capture),
         .rd_id      (req_ids[g][ID_BITS-1:0]),
         .upd_en     (cmd.update && map_en[g]),
         .distinct   (distinct[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
      end else if (cmd.clear_step) begin
         clear_addr_ff <= clear_addr_ff + ADDR_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_kind;
         scope_ff <= req_scope;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_KINDS; k++) begin
            event_counts_ff[k] <= '0;
         end
         for (int s = 0; s < NUM_SCOPES; s++) begin
            scope_counts_ff[s] <= '0;
         end
      end else if (cmd.update) begin
         for (int k = 0; k < NUM_KINDS; k++) begin
            if (kind_ff == KIND_BITS'(k) && !(&event_counts_ff[k])) begin
               event_counts_ff[k] <= event_counts_ff[k] + COUNT_BITS'(1);
            end
         end
         for (int s = 0; s < NUM_SCOPES; s++) begin
            if (scope_ff[s] && !(&scope_counts_ff[s])) begin
               scope_counts_ff[s] <= scope_counts_ff[s] + COUNT_BITS'(1);
            end
         end
      end
   end

   // report beat selection; wide counters clip to 32 bits
   assign scope_sel = idx_ff - STAT_FIRST_SCOPE;
   assign dist_sel  = idx_ff - STAT_FIRST_DIST;

   always_comb begin
      if (idx_ff < STAT_FIRST_SCOPE) begin
         wide_val = WIDE_BITS'(event_counts_ff[idx_ff[KIND_BITS-1:0]]);
      end else if (idx_ff < STAT_FIRST_DIST) begin
         wide_val = WIDE_BITS'(scope_counts_ff[scope_sel[1:0]]);
      end else begin
         wide_val = WIDE_BITS'(distinct[dist_sel[1:0]]);
      end
      if (wide_val[WIDE_BITS-1:STAT_BITS] != '0) begin
         stat_in = '1;
      end else begin
         stat_in = wide_val[STAT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.rep_start) begin
         idx_ff <= '0;
      end else if (cmd.rep_load) begin
         idx_ff <= idx_ff + INDEX_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rep_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rep_load) begin
         rsp_index_ff <= idx_ff;
         rsp_value_ff <= stat_in;
         rsp_last_ff  <= (idx_ff == STAT_LAST);
      end
   end

   assign status.clear_last = &clear_addr_ff;
   assign status.rep_last   = (idx_ff == STAT_LAST);
   assign status.rsp_valid  = rsp_valid_ff;

   assign rsp_index = rsp_index_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_last  = rsp_last_ff;

endmodule
`default_nettype wire

@@ rtl/tes_control.sv @@
// Controller: clear sweep after reset, event accept and update, report sequencing.
`default_nettype none
module tes_control (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_op,
   input  wire logic                    req_kind_ok,
   input  wire logic                    rsp_ready,
   input  wire tes_pkg::tes_status_type status,
   output      tes_pkg::tes_cmd_type    cmd,
   output      logic                    req_ready
);
   import tes_pkg::*;

   tes_state_type state_ff;
   tes_state_type state_in;
   logic          out_free;

   assign out_free = !status.rsp_valid || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_REPORT) begin
                  state_in = ST_REPORT;
               end else if (req_kind_ok) begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         ST_REPORT: begin
            if (out_free && status.rep_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.rep_start = (req_op == OP_REPORT);
               cmd.capture   = (req_op == OP_RECORD) && req_kind_ok;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         ST_REPORT: begin
            cmd.rep_load = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ rtl/trace_event_statistics_core.sv @@
// Trace event statistics core: top level joining controller and datapath.
//
// Input channel req_*: one beat per trace item. req_tuser selects the operation
// (record event or emit report); req_tdata carries kind, scope flags and ids.
// Result channel rsp_*: a report emits 14 beats, stat index 0..13, tlast on 13.
// A record event produces no beat.
//
// A record passes through the bitmap row read, then write-back and counter
// update, and no new event is accepted until the update is done. An event
// of kind seven is accepted and changes nothing. A report is accepted in
// idle and then loads a beat whenever the output register is free; the
// 64-bit bitmap row read-modify-write sets the event rate.
// After reset the four bitmaps are swept to zero, one 64-bit row per cycle
// (2^(ID_BITS-6) rows, 1024 at ID_BITS = 16); req_tready stays low then.
// A stalled receiver holds the current beat in the output register; the
// report waits for it, and a new item is accepted once the last beat is loaded.
`default_nettype none
module trace_event_statistics_core #(
   parameter int ID_BITS    = tes_pkg::ID_BITS_DEF,
   parameter int COUNT_BITS = tes_pkg::COUNT_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   // [2:0] event_kind, [5:3] scope_flags, [21:6] node_id, [37:22] context_id,
   // [53:38] entity_id, [69:54] state_id, [71:70] zero
   input  wire logic [tes_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // [0] operation
   input  wire logic                               req_tuser,
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [3:0] stat_index, [35:4] stat_value, [39:36] zero
   output      logic [tes_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output      logic                               rsp_tlast
);
   import tes_pkg::*;

   tes_cmd_type    cmd;
   tes_status_type status;

   logic [KIND_BITS-1:0]                    req_kind;
   logic [SCOPE_BITS-1:0]                   req_scope;
   logic [NUM_MAPS-1:0][ID_FIELD_BITS-1:0]  req_ids;
   logic [INDEX_BITS-1:0]                   rsp_index;
   logic [STAT_BITS-1:0]                    rsp_value;

   assign req_kind   = req_tdata[2:0];
   assign req_scope  = req_tdata[5:3];
   assign req_ids[0] = req_tdata[21:6];
   assign req_ids[1] = req_tdata[37:22];
   assign req_ids[2] = req_tdata[53:38];
   assign req_ids[3] = req_tdata[69:54];

   tes_control u_control (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_op      (req_tuser),
      .req_kind_ok (req_kind != KIND_INVALID),
      .rsp_ready   (rsp_tready),
      .status      (status),
      .cmd         (cmd),
      .req_ready   (req_tready)
   );

   tes_datapath #(
      .ID_BITS    (ID_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_kind  (req_kind),
      .req_scope (req_scope),
      .req_ids   (req_ids),
      .rsp_ready (rsp_tready),
      .rsp_index (rsp_index),
      .rsp_value (rsp_value),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tvalid = status.rsp_valid;
   assign rsp_tdata  = {4'b0000, rsp_value, rsp_index};

endmodule
`default_nettype wire
